// ===== src/tsd_pkg.sv =====
// Shared types and constants of the tone segment detector.
package tsd_pkg;

  localparam int MAX_HALF_WINDOW_DEF = 32;
  localparam int INDEX_BITS_DEF      = 16;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 17;
  localparam int HW_W     = 6;
  localparam int ENERGY_W = 34;
  localparam int POS_W    = 16;
  localparam int EDGE_W   = 2;
  localparam int FILL_W   = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  localparam logic [FILL_W-1:0]   FILL_SAT   = 8'd255;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  localparam logic [COEFF_W-1:0]  TONE_COEFF_RST      = 17'd30467;
  localparam logic [HW_W-1:0]     HALF_WINDOW_RST     = 6'd20;
  localparam logic [ENERGY_W-1:0] QUIET_THRESHOLD_RST = 34'd5368709;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_TONE_COEFF      = 2'd0;
  localparam logic [1:0] REG_HALF_WINDOW     = 2'd1;
  localparam logic [1:0] REG_QUIET_THRESHOLD = 2'd2;

  // Edge event codes
  localparam logic [EDGE_W-1:0] EDGE_NONE  = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_START = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_END   = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } sample_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] window_average;
    logic [POS_W-1:0]    position;
    logic [EDGE_W-1:0]   edge_event;
    logic                last_result;
  } result_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                is_last;
  } job_t;

endpackage

// ===== src/tsd_front.sv =====
// Front part: accept samples and compute the residual energy of each.
module tsd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  tsd_pkg::sample_item_t          sample_item,
  input  logic [tsd_pkg::COEFF_W-1:0]    tone_coeff,
  output logic                           job_valid,
  input  logic                           job_ready,
  output tsd_pkg::job_t                  job
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MAG, S_SQR, S_PUSH} state_t;

  state_t state;
  logic signed [15:0] x1, x2, cur_x;
  logic               cur_last, cur_zero;
  logic [1:0]         fcnt;
  logic signed [32:0] prod;
  logic signed [34:0] base;
  logic [30:0]        mag;
  logic               sat;
  logic [61:0]        sq;

  logic signed [34:0] r_c;
  logic [34:0]        abs_c;
  logic [62:0]        rnd_c;

  always_comb begin
    r_c   = base - 35'(prod);
    abs_c = r_c[34] ? 35'(-r_c) : 35'(r_c);
    rnd_c = 63'(sq) + 63'(64'd1 << 27);
  end

  assign sample_ready = (state == S_IDLE);
  assign job_valid    = (state == S_PUSH);
  assign job.is_last  = cur_last;
  assign job.energy   = (cur_zero) ? '0 :
                        (sat ? tsd_pkg::ENERGY_MAX : rnd_c[61:28]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      x1    <= '0;
      x2    <= '0;
      fcnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            cur_x    <= sample_item.sample;
            cur_last <= sample_item.is_last;
            cur_zero <= (fcnt < 2'd2);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= $signed(tone_coeff) * x1;
          base <= 35'(cur_x) * 35'sd16384 + 35'(x2) * 35'sd16384;
          // advance history; a record end clears it
          if (cur_last) begin
            x1   <= '0;
            x2   <= '0;
            fcnt <= '0;
          end else begin
            x1 <= cur_x;
            x2 <= x1;
            if (fcnt != 2'd2) fcnt <= fcnt + 2'd1;
          end
          state <= S_MAG;
        end
        S_MAG: begin
          sat   <= (abs_c >= 35'(64'd1 << 31));
          mag   <= abs_c[30:0];
          state <= S_SQR;
        end
        S_SQR: begin
          sq    <= mag * mag;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/tsd_queue.sv =====
// Two-entry queue between front and back parts.
module tsd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tsd_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tsd_pkg::job_t rd_data
);

  tsd_pkg::job_t slots [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_data;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/tsd_back.sv =====
// Back part: energy history, window sums, division, edge search and results.
module tsd_back #(
  parameter int MAX_HALF_WINDOW = tsd_pkg::MAX_HALF_WINDOW_DEF,
  parameter int INDEX_BITS      = tsd_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  tsd_pkg::job_t                  job,
  input  logic [tsd_pkg::HW_W-1:0]       half_window,
  input  logic [tsd_pkg::ENERGY_W-1:0]   quiet_threshold,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tsd_pkg::result_item_t          result_item
);

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = tsd_pkg::ENERGY_W + CNT_W;
  localparam int NUM_W = SUM_W + 1;
  localparam int DC_W  = $clog2(NUM_W + 1);
  localparam int W9    = tsd_pkg::FILL_W + 1;

  localparam logic [1:0] PH_SEEK_START = 2'd0;
  localparam logic [1:0] PH_SEEK_END   = 2'd1;
  localparam logic [1:0] PH_DONE       = 2'd2;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_RD, S_ACC, S_DIV, S_FIN, S_OUT} state_t;

  state_t state;
  logic [tsd_pkg::ENERGY_W-1:0] mem [DEPTH];
  logic [tsd_pkg::ENERGY_W-1:0] rd_data;

  logic [IDX_W-1:0]          head, pending, lag, idx, hi;
  logic [tsd_pkg::FILL_W-1:0] fill;
  logic [INDEX_BITS-1:0]     count;
  logic [1:0]                phase;
  logic                      rec_last, final_flag;
  logic [CNT_W-1:0]          cnt, rem;
  logic [SUM_W-1:0]          sum;
  logic [NUM_W-1:0]          num;
  logic [DC_W-1:0]           dcount;

  logic [tsd_pkg::HW_W-1:0] w_eff;
  logic [IDX_W-1:0]  w_ext, lag_c, lo_c, hi_c, head_new, rd_addr;
  logic [W9-1:0]     hi_sum, hi_fill, span;
  logic              emit_now, in_range;
  logic [CNT_W:0]    rem_sh;
  logic              qbit;
  logic [tsd_pkg::ENERGY_W-1:0] avg_c;

  always_comb begin
    w_eff = (half_window > tsd_pkg::HW_W'(MAX_HALF_WINDOW)) ?
            tsd_pkg::HW_W'(MAX_HALF_WINDOW) : half_window;
    w_ext = IDX_W'(w_eff);
    lag_c = pending - IDX_W'(1);
    emit_now = (pending != '0) && (rec_last || (lag_c >= w_ext));
    lo_c  = (lag_c > w_ext) ? lag_c - w_ext : '0;
    hi_sum  = W9'(lag_c) + W9'(w_ext);
    hi_fill = W9'(fill) - W9'(1);
    hi_c    = (hi_sum < hi_fill) ? IDX_W'(hi_sum) : IDX_W'(hi_fill);
    head_new = (fill == '0) ? '0 :
               ((head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1));
    rd_addr = (head >= idx) ? head - idx : IDX_W'((IDX_W+1)'(head) + (IDX_W+1)'(DEPTH)
                                                  - (IDX_W+1)'(idx));
    rem_sh = {rem, num[NUM_W-1]};
    qbit   = (rem_sh >= (CNT_W+1)'(cnt));
    avg_c  = (num > NUM_W'(tsd_pkg::ENERGY_MAX)) ? tsd_pkg::ENERGY_MAX
                                                 : num[tsd_pkg::ENERGY_W-1:0];
    span     = W9'(fill) - W9'(1) - W9'(lag);
    in_range = (span >= W9'(w_eff >> 1)) && (W9'(lag) >= W9'(w_eff >> 1));
  end

  assign job_ready    = (state == S_IDLE);
  assign result_valid = (state == S_OUT);

  // history store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) mem[head_new] <= job.energy;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      fill     <= '0;
      pending  <= '0;
      count    <= '0;
      phase    <= PH_SEEK_START;
      rec_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            head     <= head_new;
            if (fill != tsd_pkg::FILL_SAT) fill <= fill + tsd_pkg::FILL_W'(1);
            pending  <= pending + IDX_W'(1);
            rec_last <= job.is_last;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_now) begin
            lag        <= lag_c;
            final_flag <= rec_last && (pending == IDX_W'(1));
            idx        <= lo_c;
            hi         <= hi_c;
            cnt        <= CNT_W'(hi_c - lo_c) + CNT_W'(1);
            sum        <= '0;
            state      <= S_RD;
          end else begin
            if (rec_last) begin
              head    <= '0;
              fill    <= '0;
              pending <= '0;
              count   <= '0;
              phase   <= PH_SEEK_START;
            end else begin
              count <= count + INDEX_BITS'(1);
            end
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_ACC;
        S_ACC: begin
          sum <= sum + SUM_W'(rd_data);
          if (idx == hi) begin
            state <= S_DIV;
            // preload numerator for rounding half up
            num    <= NUM_W'(sum + SUM_W'(rd_data)) + NUM_W'(cnt >> 1);
            rem    <= '0;
            dcount <= DC_W'(NUM_W);
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end
        end
        S_DIV: begin
          rem    <= qbit ? CNT_W'(rem_sh - (CNT_W+1)'(cnt)) : CNT_W'(rem_sh);
          num    <= {num[NUM_W-2:0], qbit};
          dcount <= dcount - DC_W'(1);
          if (dcount == DC_W'(1)) state <= S_FIN;
        end
        S_FIN: begin
          result_item.window_average <= avg_c;
          result_item.position <= tsd_pkg::POS_W'(count - INDEX_BITS'(lag));
          result_item.last_result <= final_flag;
          result_item.edge_event <= tsd_pkg::EDGE_NONE;
          if (in_range) begin
            priority if (phase == PH_SEEK_START && avg_c <= quiet_threshold) begin
              result_item.edge_event <= tsd_pkg::EDGE_START;
              phase <= PH_SEEK_END;
            end else if (phase == PH_SEEK_END && avg_c >= quiet_threshold) begin
              result_item.edge_event <= tsd_pkg::EDGE_END;
              phase <= PH_DONE;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            pending <= pending - IDX_W'(1);
            state   <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/tone_segment_detector_unit.sv =====
// Top level of the tone segment detector: register port, front, queue, back.
// An accepted item passes the multiply, magnitude and square states into the queue;
// per average the back does a check, a read and add per window entry, 42 division
// steps, a finish and a result. The front takes a new sample only once its last job
// is pushed; the back's serial window sum and bit-serial divider set the rate.
// Reset (rst, synchronous): registers return to defaults, record state clears.
module tone_segment_detector_unit #(
  parameter int MAX_HALF_WINDOW = tsd_pkg::MAX_HALF_WINDOW_DEF,
  parameter int INDEX_BITS      = tsd_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  tsd_pkg::sample_item_t         sample_item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output tsd_pkg::result_item_t         result_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0]    paddr,
  input  logic [tsd_pkg::DATA_W-1:0]    pwdata,
  output logic [tsd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [tsd_pkg::COEFF_W-1:0]  tone_coeff;
  logic [tsd_pkg::HW_W-1:0]     half_window;
  logic [tsd_pkg::ENERGY_W-1:0] quiet_threshold;

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  tsd_pkg::job_t fq_job, qb_job;

  assign pready = 1'b1;

  // Registers sit at 8-byte strides; decode on paddr[4:3].
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_coeff      <= tsd_pkg::TONE_COEFF_RST;
      half_window     <= tsd_pkg::HALF_WINDOW_RST;
      quiet_threshold <= tsd_pkg::QUIET_THRESHOLD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        tsd_pkg::REG_TONE_COEFF:      tone_coeff <= pwdata[tsd_pkg::COEFF_W-1:0];
        tsd_pkg::REG_HALF_WINDOW:     half_window <= pwdata[tsd_pkg::HW_W-1:0];
        tsd_pkg::REG_QUIET_THRESHOLD: quiet_threshold <= pwdata[tsd_pkg::ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      tsd_pkg::REG_TONE_COEFF:      prdata = tsd_pkg::DATA_W'(tone_coeff);
      tsd_pkg::REG_HALF_WINDOW:     prdata = tsd_pkg::DATA_W'(half_window);
      tsd_pkg::REG_QUIET_THRESHOLD: prdata = tsd_pkg::DATA_W'(quiet_threshold);
      default:                      prdata = '0;
    endcase
  end

  // Front: compute one residual energy per sample.
  tsd_front u_front (
    .clk, .rst,
    .sample_valid, .sample_ready, .sample_item,
    .tone_coeff,
    .job_valid (fq_valid), .job_ready (fq_ready), .job (fq_job)
  );

  // Queue: lets the front run ahead while the back emits averages.
  tsd_queue u_queue (
    .clk, .rst,
    .wr_valid (fq_valid), .wr_ready (fq_ready), .wr_data (fq_job),
    .rd_valid (qb_valid), .rd_ready (qb_ready), .rd_data (qb_job)
  );

  // Back: history, windowed mean, edge search, result register.
  tsd_back #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .INDEX_BITS      (INDEX_BITS)
  ) u_back (
    .clk, .rst,
    .job_valid (qb_valid), .job_ready (qb_ready), .job (qb_job),
    .half_window, .quiet_threshold,
    .result_valid, .result_ready, .result_item
  );

endmodule
